FILE: hdl/dcw_pkg.sv
// Shared types, codes and constants of the decaying cosine wiggle.
// Holds the controller/datapath command and status structs and the cosine table function.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dcw_pkg;

  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_RATE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_RATE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_ZERO   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_USE_RAW_TIME = 2'd3;

  localparam int RATE_W  = 24;
  localparam int DT_W    = 16;
  localparam int ENV_W   = 17;
  localparam int VALUE_W = 18;

  localparam logic [RATE_W-1:0] RATE_RESET = 24'd65536;
  localparam logic [ENV_W-1:0]  ENV_ONE    = 17'd65536;

  typedef struct packed {
    logic accept;
    logic step_phase;
    logic step_env;
    logic mul_value;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic tick_run;
  } stat_t;

  // Magnitude of one cosine table entry, rounded to vfb fraction bits.
  function automatic logic [63:0] cos_mag_entry(input int idx, input int tbits,
                                                input int vfb);
    logic [63:0] pi_q30;
    logic [63:0] one_q30;
    logic [63:0] quarter;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] term;
    pi_q30  = 64'd3373259426;
    one_q30 = 64'd1 << 30;
    quarter = 64'd1 << (tbits - 2);
    q = 64'(idx) >> (tbits - 2);
    r = 64'(idx) & (quarter - 64'd1);
    if (q == 64'd0 || q == 64'd2) begin
      x = (r * 64'd2 * pi_q30) >> tbits;
    end else begin
      x = ((quarter - r) * 64'd2 * pi_q30) >> tbits;
    end
    x2 = (x * x) >> 30;
    t = one_q30;
    term = ((x2 * t) >> 30) / 64'd90;
    t = (term >= one_q30) ? 64'd0 : one_q30 - term;
    term = ((x2 * t) >> 30) / 64'd56;
    t = (term >= one_q30) ? 64'd0 : one_q30 - term;
    term = ((x2 * t) >> 30) / 64'd30;
    t = (term >= one_q30) ? 64'd0 : one_q30 - term;
    term = ((x2 * t) >> 30) / 64'd12;
    t = (term >= one_q30) ? 64'd0 : one_q30 - term;
    term = ((x2 * t) >> 30) / 64'd2;
    t = (term >= one_q30) ? 64'd0 : one_q30 - term;
    return (t + (64'd1 << (29 - vfb))) >> (30 - vfb);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/dcw_ctrl.sv
// Sequencer of the decaying cosine wiggle: input handshake, step order, output valid.
// Drives the datapath through dcw_pkg::cmd_t and reads dcw_pkg::stat_t.
// Depends on dcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire dcw_pkg::stat_t stat_i,
  output dcw_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_ENV,
    S_VAL,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = stat_i.tick_run ? S_DEC : S_EMIT;
        end
      end
      S_DEC: begin
        cmd_o.step_phase = 1'b1;
        state_d = S_ENV;
      end
      S_ENV: begin
        cmd_o.step_env = 1'b1;
        state_d = S_VAL;
      end
      S_VAL: begin
        cmd_o.mul_value = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hdl/dcw_datapath.sv
// Datapath of the decaying cosine wiggle: settings, phase, envelope, shared multiplier,
// cosine table and output beat registers. Steered by dcw_pkg::cmd_t.
// Depends on dcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcw_datapath #(
  parameter int PHASE_BITS      = 16,
  parameter int COS_TABLE_BITS  = 8,
  parameter int VALUE_FRAC_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [dcw_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  wire logic [dcw_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic [dcw_pkg::KIND_W-1:0]          kind_i,
  input  wire logic [dcw_pkg::DT_W-1:0]            delta_time_i,
  input  wire logic [dcw_pkg::DT_W-1:0]            raw_delta_time_i,
  input  wire dcw_pkg::cmd_t                       cmd_i,
  output dcw_pkg::stat_t                           stat_o,
  output logic signed [dcw_pkg::VALUE_W-1:0]       value_o,
  output logic                                     running_o,
  output logic                                     finished_o
);

  localparam int TableSize = 1 << COS_TABLE_BITS;
  localparam int MagW      = VALUE_FRAC_BITS + 1;
  localparam int MulA      = (MagW > dcw_pkg::RATE_W) ? MagW : dcw_pkg::RATE_W;
  localparam int MulB      = dcw_pkg::ENV_W;
  localparam int MulP      = MulA + MulB;
  localparam int RndW      = MulP - 15;
  localparam int StartInt  = (VALUE_FRAC_BITS >= 17) ? 131071 : (1 << VALUE_FRAC_BITS);
  localparam logic signed [dcw_pkg::VALUE_W-1:0] ValueStart = dcw_pkg::VALUE_W'(StartInt);
  localparam logic [PHASE_BITS-1:0] PhaseQuarter = PHASE_BITS'(64'd1 << (PHASE_BITS - 2));
  localparam logic [RndW-1:0] PosMax = RndW'(131071);
  localparam logic [RndW-1:0] NegMax = RndW'(131072);

  logic [dcw_pkg::RATE_W-1:0]  decay_rate_q, phase_rate_q;
  logic                        start_zero_q, use_raw_q;
  logic [PHASE_BITS-1:0]       phase_q, phase_d;
  logic [dcw_pkg::ENV_W-1:0]   env_q, env_d;
  logic signed [dcw_pkg::VALUE_W-1:0] held_q, held_d;
  logic                        active_q, active_d;
  logic                        finished_q, finished_d;
  logic                        run_q, run_d;
  logic [dcw_pkg::DT_W-1:0]    dt_q, dt_sel;
  logic [MulP-1:0]             prod_q, prod_d;
  logic [MulA-1:0]             mul_a;
  logic [MulB-1:0]             mul_b;
  logic                        prod_en;
  logic [dcw_pkg::RATE_W-1:0]  dec;
  logic [MagW-1:0]             cos_lut [TableSize];
  logic [COS_TABLE_BITS-1:0]   idx;
  logic                        neg;
  logic [MulP:0]               rnd;
  logic [RndW-1:0]             rounded;
  logic signed [dcw_pkg::VALUE_W-1:0] sat_val;
  logic signed [dcw_pkg::VALUE_W-1:0] out_value_q;
  logic                        out_running_q, out_finished_q;

  for (genvar g = 0; g < TableSize; g++) begin : g_lut
    assign cos_lut[g] = MagW'(dcw_pkg::cos_mag_entry(g, COS_TABLE_BITS, VALUE_FRAC_BITS));
  end

  if (PHASE_BITS >= COS_TABLE_BITS) begin : g_idx_hi
    assign idx = phase_q[PHASE_BITS-1 -: COS_TABLE_BITS];
  end else begin : g_idx_lo
    assign idx = {phase_q, {(COS_TABLE_BITS - PHASE_BITS){1'b0}}};
  end

  assign neg    = idx[COS_TABLE_BITS-1] ^ idx[COS_TABLE_BITS-2];
  assign dt_sel = use_raw_q ? raw_delta_time_i : delta_time_i;
  assign stat_o.tick_run = (kind_i == dcw_pkg::KIND_TICK) && active_q;
  assign dec = prod_q[16 +: dcw_pkg::RATE_W];

  always_comb begin
    mul_a   = MulA'(phase_rate_q);
    mul_b   = MulB'(dt_sel);
    prod_en = 1'b0;
    if (cmd_i.accept) begin
      prod_en = 1'b1;
    end else if (cmd_i.step_phase) begin
      mul_a   = MulA'(decay_rate_q);
      mul_b   = MulB'(dt_q);
      prod_en = 1'b1;
    end else if (cmd_i.mul_value) begin
      mul_a   = MulA'(cos_lut[idx]);
      mul_b   = env_q;
      prod_en = 1'b1;
    end
    prod_d = MulP'(mul_a) * MulP'(mul_b);
  end

  always_comb begin
    rnd     = (MulP + 1)'(prod_q) + (MulP + 1)'(32768);
    rounded = rnd[MulP:16];
    if (neg) begin
      sat_val = (rounded > NegMax) ? -18'sd131072
                                   : dcw_pkg::VALUE_W'(RndW'(0) - rounded);
    end else begin
      sat_val = (rounded > PosMax) ? 18'sd131071 : dcw_pkg::VALUE_W'(rounded);
    end
  end

  always_comb begin
    phase_d    = phase_q;
    env_d      = env_q;
    held_d     = held_q;
    active_d   = active_q;
    finished_d = finished_q;
    run_d      = run_q;
    if (cmd_i.accept) begin
      finished_d = 1'b0;
      run_d      = stat_o.tick_run;
      case (kind_i)
        dcw_pkg::KIND_START: begin
          env_d    = dcw_pkg::ENV_ONE;
          active_d = 1'b1;
          phase_d  = start_zero_q ? PhaseQuarter : '0;
          held_d   = start_zero_q ? '0 : ValueStart;
        end
        dcw_pkg::KIND_STOP: begin
          active_d = 1'b0;
          held_d   = '0;
        end
        default: ;
      endcase
    end
    if (cmd_i.step_phase) begin
      phase_d = phase_q + prod_q[32-PHASE_BITS +: PHASE_BITS];
    end
    if (cmd_i.step_env) begin
      if (dec >= dcw_pkg::RATE_W'(env_q)) begin
        env_d      = '0;
        active_d   = 1'b0;
        finished_d = 1'b1;
      end else begin
        env_d = env_q - dcw_pkg::ENV_W'(dec);
      end
    end
    if (cmd_i.emit && run_q) begin
      held_d = sat_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_rate_q <= dcw_pkg::RATE_RESET;
      phase_rate_q <= dcw_pkg::RATE_RESET;
      start_zero_q <= 1'b0;
      use_raw_q    <= 1'b0;
      phase_q      <= '0;
      env_q        <= '0;
      held_q       <= '0;
      active_q     <= 1'b0;
      finished_q   <= 1'b0;
      run_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          dcw_pkg::CFG_DECAY_RATE:   decay_rate_q <= cfg_wdata_i;
          dcw_pkg::CFG_PHASE_RATE:   phase_rate_q <= cfg_wdata_i;
          dcw_pkg::CFG_START_ZERO:   start_zero_q <= cfg_wdata_i[0];
          dcw_pkg::CFG_USE_RAW_TIME: use_raw_q    <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      phase_q    <= phase_d;
      env_q      <= env_d;
      held_q     <= held_d;
      active_q   <= active_d;
      finished_q <= finished_d;
      run_q      <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dt_q <= dt_sel;
    end
    if (prod_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.emit) begin
      out_value_q    <= held_d;
      out_running_q  <= active_q;
      out_finished_q <= finished_q;
    end
  end

  assign value_o    = out_value_q;
  assign running_o  = out_running_q;
  assign finished_o = out_finished_q;

endmodule

`default_nettype wire

FILE: hdl/decaying_cosine_wiggle.sv
// Decaying cosine wiggle: a cosine wave under a linearly falling envelope.
// A running tick passes S_IDLE, S_DEC, S_ENV, S_VAL and S_EMIT: one shared multiplier
// forms the phase step, the envelope step and the cosine-times-envelope product one
// after another. Start, stop-and-clear and idle ticks go from S_IDLE to S_EMIT. The
// input is stalled while an item is in work; a finished result beat waits in the
// output register, so the next item is accepted even while that beat is stalled.
// Depends on dcw_pkg, dcw_ctrl and dcw_datapath.
`timescale 1ns / 1ps
`default_nettype none

module decaying_cosine_wiggle #(
  parameter int PHASE_BITS      = 16,
  parameter int COS_TABLE_BITS  = 8,
  parameter int VALUE_FRAC_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dcw_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [dcw_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [dcw_pkg::KIND_W-1:0]       kind_i,
  input  wire logic [dcw_pkg::DT_W-1:0]         delta_time_i,
  input  wire logic [dcw_pkg::DT_W-1:0]         raw_delta_time_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic signed [dcw_pkg::VALUE_W-1:0]    value_o,
  output logic                                  running_o,
  output logic                                  finished_o
);

  dcw_pkg::cmd_t  cmd;
  dcw_pkg::stat_t stat;

  dcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dcw_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .COS_TABLE_BITS  (COS_TABLE_BITS),
    .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .kind_i           (kind_i),
    .delta_time_i     (delta_time_i),
    .raw_delta_time_i (raw_delta_time_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .value_o          (value_o),
    .running_o        (running_o),
    .finished_o       (finished_o)
  );

endmodule

`default_nettype wire

FILE: tb/dcw_wiggle_checker.sv
// Checker for the decaying cosine wiggle: watches the config port and both channels.
// Keeps its own model of phase, envelope and held value, and compares every result beat.
// Depends on dcw_pkg.
`timescale 1ns / 1ps

module dcw_wiggle_checker
  import dcw_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic [DT_W-1:0]           delta_time_i,
  input  logic [DT_W-1:0]           raw_delta_time_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      running_i,
  input  logic                      finished_i,
  output int                        pending_o,
  output int                        fail_count_o
);

  localparam int PHASE_W = 16;
  localparam int LUT_BITS = 8;
  localparam int LUT_SIZE = 1 << LUT_BITS;
  localparam int QUARTER = LUT_SIZE / 4;
  localparam longint VALUE_MAX = 131071;
  localparam longint VALUE_MIN = -131072;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      running;
    logic                      finished;
  } wiggle_beat_t;

  int cos_lut[LUT_SIZE];

  logic [RATE_W-1:0]         decay_rate;
  logic [RATE_W-1:0]         phase_rate;
  logic                      start_zero;
  logic                      use_raw_time;
  logic [PHASE_W-1:0]        phase;
  logic [ENV_W-1:0]          envelope;
  logic signed [VALUE_W-1:0] held_value;
  logic                      active;

  wiggle_beat_t expected_beats[$];
  int mismatches;

  function automatic longint unsigned series_cos(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned term;
    longint unsigned divisor;
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: divisor = 90;
        1: divisor = 56;
        2: divisor = 30;
        3: divisor = 12;
        default: divisor = 2;
      endcase
      term = ((x2 * t) >> 30) / divisor;
      t = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
    end
    return (t + (64'd1 << 13)) >> 14;
  endfunction

  initial begin : build_lut
    int quad;
    longint unsigned r;
    longint unsigned mag;
    for (int i = 0; i < LUT_SIZE; i++) begin
      quad = i / QUARTER;
      r = longint'(i % QUARTER);
      if (quad == 0 || quad == 2) begin
        mag = series_cos((r * 2 * PI_Q30) >> LUT_BITS);
      end else begin
        mag = series_cos(((QUARTER - r) * 2 * PI_Q30) >> LUT_BITS);
      end
      cos_lut[i] = (quad == 1 || quad == 2) ? -int'(mag) : int'(mag);
    end
  end

  function automatic logic signed [VALUE_W-1:0] enveloped_cos();
    int c;
    longint unsigned mag;
    longint unsigned prod;
    longint v;
    c = cos_lut[phase[PHASE_W-1 -: LUT_BITS]];
    mag = longint'(c < 0 ? -c : c);
    prod = (mag * envelope + 64'd32768) >> 16;
    v = (c < 0) ? -longint'(prod) : longint'(prod);
    if (v > VALUE_MAX) v = VALUE_MAX;
    if (v < VALUE_MIN) v = VALUE_MIN;
    return VALUE_W'(v);
  endfunction

  function automatic wiggle_beat_t apply_beat(logic [KIND_W-1:0] kind, logic [DT_W-1:0] dt,
                                              logic [DT_W-1:0] raw_dt);
    wiggle_beat_t beat;
    logic [DT_W-1:0] step;
    longint unsigned turn_add;
    longint unsigned env_drop;
    beat.finished = 1'b0;
    case (kind)
      KIND_START: begin
        envelope = ENV_ONE;
        if (start_zero) begin
          phase = PHASE_W'(1) << (PHASE_W - 2);
          held_value = '0;
        end else begin
          phase = '0;
          held_value = VALUE_W'(65536);
        end
        active = 1'b1;
      end
      KIND_STOP: begin
        active = 1'b0;
        held_value = '0;
      end
      KIND_TICK: begin
        if (active) begin
          step = use_raw_time ? raw_dt : dt;
          turn_add = (64'(phase_rate) * 64'(step)) >> (32 - PHASE_W);
          env_drop = (64'(decay_rate) * 64'(step)) >> 16;
          phase = phase + PHASE_W'(turn_add);
          if (env_drop >= 64'(envelope)) begin
            envelope = '0;
            active = 1'b0;
            beat.finished = 1'b1;
          end else begin
            envelope = envelope - ENV_W'(env_drop);
          end
          held_value = enveloped_cos();
        end
      end
      default: ;
    endcase
    beat.value = held_value;
    beat.running = active;
    return beat;
  endfunction

  task automatic record_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    wiggle_beat_t want;
    if (!rst_ni) begin
      decay_rate = RATE_RESET;
      phase_rate = RATE_RESET;
      start_zero = 1'b0;
      use_raw_time = 1'b0;
      phase = '0;
      envelope = '0;
      held_value = '0;
      active = 1'b0;
      expected_beats.delete();
      mismatches = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          record_failure($sformatf("result beat with nothing expected: value %0d", value_i));
        end else begin
          want = expected_beats.pop_front();
          if (value_i !== want.value)
            record_failure($sformatf("value: expected %0d, got %0d", want.value, value_i));
          if (running_i !== want.running)
            record_failure($sformatf("running: expected %0b, got %0b", want.running,
                                     running_i));
          if (finished_i !== want.finished)
            record_failure($sformatf("finished: expected %0b, got %0b", want.finished,
                                     finished_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_beats.push_back(apply_beat(kind_i, delta_time_i, raw_delta_time_i));
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DECAY_RATE:   decay_rate = cfg_wdata_i[RATE_W-1:0];
          CFG_PHASE_RATE:   phase_rate = cfg_wdata_i[RATE_W-1:0];
          CFG_START_ZERO:   start_zero = cfg_wdata_i[0];
          CFG_USE_RAW_TIME: use_raw_time = cfg_wdata_i[0];
          default: ;
        endcase
      end
      pending_o <= expected_beats.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: tb/decaying_cosine_wiggle_tb.sv
// Top of the decaying cosine wiggle testbench: clock, reset, config writes and beats.
// Runs directed beats, then random start/tick runs under several settings with random stalls.
// Depends on dcw_pkg, decaying_cosine_wiggle and dcw_wiggle_checker.
`timescale 1ns / 1ps

module decaying_cosine_wiggle_tb;
  import dcw_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic [KIND_W-1:0]      kind = KIND_TICK;
  logic [DT_W-1:0]        delta_time = '0;
  logic [DT_W-1:0]        raw_delta_time = '0;
  logic                   out_stall = 1'b0;

  logic                      in_stall;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] value;
  logic                      running;
  logic                      finished;

  int pending;
  int fail_count;
  bit quiet = 1'b0;
  int stall_left = 0;

  always #5 clk = ~clk;

  decaying_cosine_wiggle dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (kind),
    .delta_time_i     (delta_time),
    .raw_delta_time_i (raw_delta_time),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .value_o          (value),
    .running_o        (running),
    .finished_o       (finished)
  );

  dcw_wiggle_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .kind_i           (kind),
    .delta_time_i     (delta_time),
    .raw_delta_time_i (raw_delta_time),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .value_i          (value),
    .running_i        (running),
    .finished_i       (finished),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  always @(posedge clk) begin
    if (out_valid && !out_stall) stall_left = quiet ? 0 : $urandom_range(0, 16);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [DT_W-1:0] rand_dt();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return DT_W'($urandom_range(0, 1023));
      4: return DT_W'($urandom_range(0, 8191));
      default: return DT_W'($urandom);
    endcase
  endfunction

  task automatic send_beat(logic [KIND_W-1:0] k, logic [DT_W-1:0] dt, logic [DT_W-1:0] raw_dt);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    delta_time <= dt;
    raw_delta_time <= raw_dt;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_config(logic [RATE_W-1:0] decay, logic [RATE_W-1:0] turns, bit zero_start,
                            bit raw_time);
    wait_drained();
    write_reg(CFG_DECAY_RATE, CFG_DATA_W'(decay));
    write_reg(CFG_PHASE_RATE, CFG_DATA_W'(turns));
    write_reg(CFG_START_ZERO, CFG_DATA_W'(zero_start));
    write_reg(CFG_USE_RAW_TIME, CFG_DATA_W'(raw_time));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_ticks(int count);
    logic [KIND_W-1:0] k;
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(0, 14) == 0) ? KIND_UNUSED : KIND_TICK;
      send_beat(k, rand_dt(), rand_dt());
    end
  endtask

  task automatic random_phase(int target);
    int sent;
    int pick;
    int ticks;
    bit paused;
    sent = 0;
    paused = 1'b0;
    while (sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        ticks = $urandom_range(1, 40);
        send_beat(KIND_START, rand_dt(), rand_dt());
        run_ticks(ticks);
        sent += ticks + 1;
        if ($urandom_range(0, 1) == 1) begin
          send_beat(KIND_STOP, rand_dt(), rand_dt());
          sent++;
        end
      end else if (pick == 7) begin
        send_beat(KIND_TICK, rand_dt(), rand_dt());
        sent++;
      end else if (pick == 8) begin
        send_beat(KIND_STOP, rand_dt(), rand_dt());
        sent++;
      end else begin
        send_beat(KIND_UNUSED, rand_dt(), rand_dt());
        sent++;
      end
      if (!paused && sent >= target / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin : stimulus
    logic [RATE_W-1:0] decay;
    logic [RATE_W-1:0] turns;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(KIND_TICK, 16'h1234, '1);
    send_beat(KIND_UNUSED, '0, '0);
    send_beat(KIND_START, '0, '0);
    send_beat(KIND_TICK, '0, '1);
    send_beat(KIND_UNUSED, '1, '1);
    send_beat(KIND_TICK, '1, '0);
    send_beat(KIND_TICK, 16'h8000, '0);
    send_beat(KIND_TICK, 16'd5, 16'd5);
    send_beat(KIND_START, '0, '0);
    send_beat(KIND_STOP, '0, '0);
    send_beat(KIND_TICK, 16'd77, 16'd77);

    set_config('0, '1, 1'b1, 1'b1);
    send_beat(KIND_START, '0, '0);
    send_beat(KIND_TICK, '0, '1);
    send_beat(KIND_TICK, '1, 16'd1);
    send_beat(KIND_TICK, '1, '1);

    set_config('1, '0, 1'b0, 1'b0);
    send_beat(KIND_START, '1, '1);
    send_beat(KIND_TICK, 16'd1, '0);
    send_beat(KIND_TICK, '1, '0);

    set_config(24'd100, 24'd100, 1'b1, 1'b0);
    send_beat(KIND_START, '0, '0);
    send_beat(KIND_TICK, 16'd1, '1);
    send_beat(KIND_TICK, 16'd700, '0);
    send_beat(KIND_STOP, '0, '0);

    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(0, 4))
        0: decay = '0;
        1: decay = '1;
        2: decay = RATE_W'($urandom_range(1, 4096));
        3: decay = RATE_W'($urandom_range(4097, 262144));
        default: decay = RATE_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: turns = '0;
        1: turns = '1;
        2: turns = RATE_W'($urandom_range(0, 1 << 20));
        default: turns = RATE_W'($urandom);
      endcase
      set_config(decay, turns, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      quiet = (p == 2);
      random_phase(250);
    end

    quiet = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
